/* hw/rtl/assoc_block_cache_oldest_evict_unit_assert.svh */
`ifndef ASSOC_BLOCK_CACHE_OLDEST_EVICT_UNIT_ASSERT_SVH
`define ASSOC_BLOCK_CACHE_OLDEST_EVICT_UNIT_ASSERT_SVH

// same-cycle implication, checked outside reset
`define ABCO_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

// next-cycle implication, checked outside reset
`define ABCO_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* hw/rtl/abco_pkg.sv */
package abco_pkg;

	localparam int MAX_SLOT_DEPTH = 16;
	localparam int BLOCK_WORDS    = 32;
	localparam int SLOT_W  = (MAX_SLOT_DEPTH > 1) ? $clog2(MAX_SLOT_DEPTH) : 1;
	localparam int FILL_W  = $clog2(MAX_SLOT_DEPTH + 1);
	localparam int BW_W    = (BLOCK_WORDS > 1) ? $clog2(BLOCK_WORDS) : 1;
	localparam int STORE_WORDS = MAX_SLOT_DEPTH * BLOCK_WORDS;
	localparam int ADDR_W  = (STORE_WORDS > 1) ? $clog2(STORE_WORDS) : 1;
	localparam int STAMP_W = 16;

	localparam logic [1:0] KIND_HIT  = 2'd0;
	localparam logic [1:0] KIND_MISS = 2'd1;
	localparam logic [1:0] KIND_PUT  = 2'd2;

	localparam logic CMD_GET = 1'b0;

	typedef struct packed {
		logic        cmd;
		logic [7:0]  device_id;
		logic [15:0] sector;
		logic [15:0] block_number;
		logic [4:0]  word_index;
		logic [63:0] write_word;
	} req_t;

	typedef struct packed {
		logic [1:0]  result_kind;
		logic [63:0] read_word;
		logic [4:0]  read_index;
		logic        last;
		logic [31:0] hits_so_far;
		logic [31:0] misses_so_far;
	} rsp_t;

	typedef struct packed {
		logic [7:0]  device_id;
		logic [15:0] sector;
		logic [15:0] block_number;
	} tag_t;

	typedef struct packed {
		logic               hit;
		logic [SLOT_W-1:0]  hit_idx;
		logic               min_any;
		logic [STAMP_W-1:0] min_stamp;
		logic [SLOT_W-1:0]  min_idx;
	} scan_t;

	typedef struct packed {
		logic               en;
		logic [SLOT_W-1:0]  slot;
		tag_t               tag;
		logic [STAMP_W-1:0] stamp;
	} cell_wr_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SEARCH,
		ST_DECIDE,
		ST_PUTWR,
		ST_RD,
		ST_WAIT,
		ST_RESP
	} state_t;

endpackage

/* hw/rtl/assoc_block_cache_oldest_evict_unit.sv */
// channel | direction | handshake            | payload
// req     | in        | req_valid/req_ready  | abco_pkg::req_t
// rsp     | out       | rsp_valid/rsp_ready  | abco_pkg::rsp_t
// cfg     | in        | cfg_we               | cfg_wdata (max_slots)
//
// Get: a tag scan through the cell chain after the accepting edge, then a miss result,
// or the hit words one at a time from the data RAM, each read (ST_RD) and then loaded (ST_WAIT).
// Put word 0: scan as above, then tag write and data write; other put words: data write only.
// One request at a time; req_ready returns the cycle after the last result loads.
// Reset clears fill count, stamp counter and statistics; tags and data stay undefined.
module assoc_block_cache_oldest_evict_unit (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           req_valid,
	output logic           req_ready,
	input  abco_pkg::req_t req,
	output logic           rsp_valid,
	input  logic           rsp_ready,
	output abco_pkg::rsp_t rsp,
	input  logic           cfg_we,
	input  logic [4:0]     cfg_wdata
);

	localparam int D = abco_pkg::MAX_SLOT_DEPTH;

	abco_pkg::state_t              state_q, state_d;
	abco_pkg::req_t                req_q;
	logic [abco_pkg::SLOT_W-1:0]   cnt_q, cnt_d;
	logic [abco_pkg::BW_W-1:0]     word_q, word_d;
	logic [1:0]                    kind_q, kind_d;
	logic [abco_pkg::FILL_W-1:0]   filled_q, filled_d;
	logic [abco_pkg::STAMP_W-1:0]  stamp_q, stamp_d;
	logic [abco_pkg::SLOT_W-1:0]   put_slot_q, put_slot_d;
	logic [abco_pkg::SLOT_W-1:0]   hit_slot_q, hit_slot_d;
	logic [31:0]                   hits_q, hits_d, misses_q, misses_d;
	logic [4:0]                    max_slots_q;
	abco_pkg::rsp_t                rsp_q, rsp_d;
	logic                          rsp_valid_q, rsp_load;
	logic                          req_take;
	logic [abco_pkg::FILL_W-1:0]   limit;
	abco_pkg::scan_t               chain [D+1];
	abco_pkg::scan_t               fin;
	abco_pkg::cell_wr_t            wr;
	abco_pkg::tag_t                key;
	logic [abco_pkg::SLOT_W-1:0]   slot_sel;
	logic                          ram_we, ram_re;
	logic [abco_pkg::ADDR_W-1:0]   ram_waddr, ram_raddr;
	logic [63:0]                   ram_rdata;
	logic                          out_free;

	assign key       = '{device_id: req_q.device_id, sector: req_q.sector,
		block_number: req_q.block_number};
	assign chain[0]  = '0;
	assign fin       = chain[D];
	assign out_free  = !rsp_valid_q || rsp_ready;
	assign req_ready = (state_q == abco_pkg::ST_IDLE);
	assign req_take  = req_valid && req_ready;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	always_comb begin
		if (max_slots_q == 5'd0) begin
			limit = abco_pkg::FILL_W'(1);
		end else if (32'(max_slots_q) > D) begin
			limit = abco_pkg::FILL_W'(D);
		end else begin
			limit = abco_pkg::FILL_W'(max_slots_q);
		end
	end

	for (genvar i = 0; i < D; i++) begin : g_cell
		abco_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.slot_id  (abco_pkg::SLOT_W'(i)),
			.filled   (abco_pkg::FILL_W'(i) < filled_q),
			.key      (key),
			.wr       (wr),
			.carry_in (chain[i]),
			.carry_out(chain[i+1])
		);
	end

	abco_ram #(
		.WIDTH(64),
		.DEPTH(abco_pkg::STORE_WORDS)
	) u_ram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(req_q.write_word),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		if (fin.hit) begin
			slot_sel = fin.hit_idx;
		end else if (filled_q < limit) begin
			slot_sel = abco_pkg::SLOT_W'(filled_q);
		end else begin
			slot_sel = fin.min_idx;
		end
	end

	always_comb begin
		state_d    = state_q;
		cnt_d      = cnt_q;
		word_d     = word_q;
		kind_d     = kind_q;
		filled_d   = filled_q;
		stamp_d    = stamp_q;
		put_slot_d = put_slot_q;
		hit_slot_d = hit_slot_q;
		hits_d     = hits_q;
		misses_d   = misses_q;
		rsp_d      = rsp_q;
		rsp_load   = 1'b0;
		wr         = '{en: 1'b0, slot: slot_sel, tag: key, stamp: stamp_q};
		ram_we     = 1'b0;
		ram_re     = 1'b0;
		ram_waddr  = abco_pkg::ADDR_W'(put_slot_q) * abco_pkg::ADDR_W'(abco_pkg::BLOCK_WORDS)
			+ abco_pkg::ADDR_W'(req_q.word_index);
		ram_raddr  = abco_pkg::ADDR_W'(hit_slot_q) * abco_pkg::ADDR_W'(abco_pkg::BLOCK_WORDS)
			+ abco_pkg::ADDR_W'(word_q);
		unique case (state_q)
			abco_pkg::ST_IDLE: begin
				if (req_take) begin
					cnt_d = '0;
					if (req.cmd == abco_pkg::CMD_GET || req.word_index == 5'd0) begin
						state_d = abco_pkg::ST_SEARCH;
					end else begin
						state_d = abco_pkg::ST_PUTWR;
					end
				end
			end
			abco_pkg::ST_SEARCH: begin
				cnt_d = cnt_q + 1'b1;
				if (32'(cnt_q) == D - 1) begin
					state_d = abco_pkg::ST_DECIDE;
				end
			end
			abco_pkg::ST_DECIDE: begin
				if (req_q.cmd == abco_pkg::CMD_GET) begin
					if (fin.hit) begin
						if (hits_q != '1) begin
							hits_d = hits_q + 1'b1;
						end
						hit_slot_d = fin.hit_idx;
						word_d     = '0;
						state_d    = abco_pkg::ST_RD;
					end else begin
						if (misses_q != '1) begin
							misses_d = misses_q + 1'b1;
						end
						kind_d  = abco_pkg::KIND_MISS;
						state_d = abco_pkg::ST_RESP;
					end
				end else begin
					wr.en      = 1'b1;
					stamp_d    = stamp_q + 1'b1;
					put_slot_d = slot_sel;
					if (!fin.hit && filled_q < limit) begin
						filled_d = filled_q + 1'b1;
					end
					state_d = abco_pkg::ST_PUTWR;
				end
			end
			abco_pkg::ST_PUTWR: begin
				ram_we  = (32'(req_q.word_index) < abco_pkg::BLOCK_WORDS);
				kind_d  = abco_pkg::KIND_PUT;
				state_d = abco_pkg::ST_RESP;
			end
			abco_pkg::ST_RD: begin
				ram_re  = 1'b1;
				state_d = abco_pkg::ST_WAIT;
			end
			abco_pkg::ST_WAIT: begin
				if (out_free) begin
					rsp_load = 1'b1;
					rsp_d    = '{result_kind: abco_pkg::KIND_HIT, read_word: ram_rdata,
						read_index: 5'(word_q),
						last: (32'(word_q) == abco_pkg::BLOCK_WORDS - 1),
						hits_so_far: hits_q, misses_so_far: misses_q};
					if (32'(word_q) == abco_pkg::BLOCK_WORDS - 1) begin
						state_d = abco_pkg::ST_IDLE;
					end else begin
						word_d  = word_q + 1'b1;
						state_d = abco_pkg::ST_RD;
					end
				end
			end
			abco_pkg::ST_RESP: begin
				if (out_free) begin
					rsp_load = 1'b1;
					rsp_d    = '{result_kind: kind_q, read_word: '0, read_index: '0,
						last: 1'b1, hits_so_far: hits_q, misses_so_far: misses_q};
					state_d  = abco_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = abco_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= abco_pkg::ST_IDLE;
			cnt_q       <= '0;
			word_q      <= '0;
			kind_q      <= abco_pkg::KIND_PUT;
			filled_q    <= '0;
			stamp_q     <= '0;
			put_slot_q  <= '0;
			hit_slot_q  <= '0;
			hits_q      <= '0;
			misses_q    <= '0;
			max_slots_q <= 5'd16;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q    <= state_d;
			cnt_q      <= cnt_d;
			word_q     <= word_d;
			kind_q     <= kind_d;
			filled_q   <= filled_d;
			stamp_q    <= stamp_d;
			put_slot_q <= put_slot_d;
			hit_slot_q <= hit_slot_d;
			hits_q     <= hits_d;
			misses_q   <= misses_d;
			if (cfg_we) begin
				max_slots_q <= cfg_wdata;
			end
			if (rsp_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_take) begin
			req_q <= req;
		end
		if (rsp_load) begin
			rsp_q <= rsp_d;
		end
	end

endmodule

/* hw/rtl/abco_ram.sv */
module abco_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 512
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

/* hw/rtl/abco_cell.sv */
module abco_cell (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic [abco_pkg::SLOT_W-1:0]      slot_id,
	input  logic                             filled,
	input  abco_pkg::tag_t                   key,
	input  abco_pkg::cell_wr_t               wr,
	input  abco_pkg::scan_t                  carry_in,
	output abco_pkg::scan_t                  carry_out
);

	abco_pkg::tag_t                    tag_q;
	logic [abco_pkg::STAMP_W-1:0]      stamp_q;
	abco_pkg::scan_t                   carry_q;
	abco_pkg::scan_t                   carry_d;

	always_comb begin
		carry_d = carry_in;
		if (filled && !carry_in.hit && tag_q == key) begin
			carry_d.hit     = 1'b1;
			carry_d.hit_idx = slot_id;
		end
		if (filled && (!carry_in.min_any || stamp_q < carry_in.min_stamp)) begin
			carry_d.min_any   = 1'b1;
			carry_d.min_stamp = stamp_q;
			carry_d.min_idx   = slot_id;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			carry_q <= '0;
		end else begin
			carry_q <= carry_d;
		end
	end

	always_ff @(posedge clk) begin
		if (wr.en && wr.slot == slot_id) begin
			tag_q   <= wr.tag;
			stamp_q <= wr.stamp;
		end
	end

	assign carry_out = carry_q;

endmodule

/* hw/rtl/abco_chk.sv */
`include "assoc_block_cache_oldest_evict_unit_assert.svh"

module abco_chk (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           rsp_valid,
	input  logic           rsp_ready,
	input  abco_pkg::rsp_t rsp
);

	`ABCO_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp), "response changed while stalled")
	`ABCO_ASSERT_NOW(a_kind_legal, rsp_valid, rsp.result_kind == abco_pkg::KIND_HIT || rsp.result_kind == abco_pkg::KIND_MISS || rsp.result_kind == abco_pkg::KIND_PUT, "illegal result kind")
	`ABCO_ASSERT_NOW(a_miss_form, rsp_valid && rsp.result_kind == abco_pkg::KIND_MISS, rsp.last && rsp.read_word == 64'd0 && rsp.read_index == 5'd0, "malformed miss result")
	`ABCO_ASSERT_NOW(a_put_form, rsp_valid && rsp.result_kind == abco_pkg::KIND_PUT, rsp.last && rsp.read_word == 64'd0 && rsp.read_index == 5'd0, "malformed put result")

endmodule

bind assoc_block_cache_oldest_evict_unit abco_chk u_abco_chk (
	.clk      (clk),
	.arst_n   (arst_n),
	.rsp_valid(rsp_valid),
	.rsp_ready(rsp_ready),
	.rsp      (rsp)
);
